### design/slms_pkg.sv
// Shared types and constants for the status LED mode sequencer.
`default_nettype none

package slms_pkg;

  // Display modes, encoded as shown on the result channel.
  typedef enum logic [2:0] {
    MODE_SLEEP       = 3'd0,
    MODE_LOCK        = 3'd1,
    MODE_MENU        = 3'd2,
    MODE_SUCCESS     = 3'd3,
    MODE_CONNECTING  = 3'd4,
    MODE_ADVERTISING = 3'd5,
    MODE_REST        = 3'd6
  } mode_t;

  // Register word indexes on the APB port.
  typedef enum logic [2:0] {
    REG_LOW_BATTERY  = 3'd0,
    REG_CONNECTING   = 3'd1,
    REG_ADVERTISING  = 3'd2,
    REG_STEP         = 3'd3,
    REG_FLASH_COUNT  = 3'd4,
    REG_USER_WINDOW  = 3'd5,
    REG_PULSE        = 3'd6,
    REG_PULSE_PERIOD = 3'd7
  } reg_idx_t;

  localparam int unsigned ApbAddrWidth = 5;
  localparam int unsigned ApbDataWidth = 32;

  localparam logic [6:0]  LowBatteryReset  = 7'd10;
  localparam logic [15:0] ConnectingReset  = 16'd4000;
  localparam logic [15:0] AdvertisingReset = 16'd60000;
  localparam logic [15:0] StepReset        = 16'd1000;
  localparam logic [3:0]  FlashCountReset  = 4'd3;
  localparam logic [15:0] UserWindowReset  = 16'd9000;
  localparam logic [15:0] PulseReset       = 16'd60;
  localparam logic [15:0] PulsePeriodReset = 16'd10000;

  localparam logic [15:0] AgeMax      = 16'hFFFF;
  localparam logic [7:0]  PhaseMax    = 8'd255;
  localparam logic [7:0]  PhaseWrap   = 8'd254;

  typedef struct packed {
    logic       usb_on;
    logic       link_connected;
    logic       slot_open;
    logic [2:0] profile_number;
    logic       caps_lock;
    logic       num_lock;
    logic [6:0] battery_percent;
    logic       sleeping;
    logic       menu_active;
    logic       success_request;
    logic       user_action;
    logic       episode_restart;
  } tick_item_t;

  typedef struct packed {
    logic       blue_on;
    logic       red_led;
    logic [2:0] shown_mode;
  } led_item_t;

endpackage

`default_nettype wire

### design/slms_if.sv
// Valid/ready channel interfaces for tick items and LED result items.
`default_nettype none

interface slms_tick_if import slms_pkg::*; ();
  logic       valid;
  logic       ready;
  tick_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface slms_led_if import slms_pkg::*; ();
  logic      valid;
  logic      ready;
  led_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

### design/status_led_mode_sequencer_top.sv
// Status LED mode sequencer: input register, one-pass mode logic, result register.
//
// Usage: one tick item per millisecond arrives on the tick channel (valid/ready).
// It carries link, host and battery status. For every accepted tick the block
// returns exactly one item on the status channel: blue_on, red_led and the
// shown mode (sleep, lock, menu, success, connecting, advertising, rest).
// A tick is registered in the input register; the mode logic then writes state
// and the result register in one pass. Throughput: one item per clock while
// status.ready is high. The input register refills while the result register
// is being drained, so both stages keep moving; when the receiver stalls, the
// result holds, the input register holds the next tick, and tick.ready drops
// only once both are full.
// Reset (rst, synchronous, active high): both stages empty, mode = rest, all
// timers and edge-detect flags zero, user-action age saturated (window
// expired), registers at their defaults (10, 4000, 60000, 1000, 3, 9000, 60,
// 10000). Registers are written over APB (word index = paddr[4:2]); the user must
// write them only while idle, and the block itself does not enforce this. pready
// is tied high and reads return the register value.
`default_nettype none

module status_led_mode_sequencer_top import slms_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  slms_tick_if.sink                    tick,
  slms_led_if.source                   status,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [ApbAddrWidth-1:0] paddr,
  input  wire logic [ApbDataWidth-1:0] pwdata,
  output logic      [ApbDataWidth-1:0] prdata,
  output logic                         pready
);

  // ---------------- configuration registers ----------------
  logic [6:0]  low_battery_percent;
  logic [15:0] reconnect_ms;
  logic [15:0] advertising_ms;
  logic [15:0] step_ms;
  logic [3:0]  flash_count;
  logic [15:0] user_window_ms;
  logic [15:0] pulse_ms;
  logic [15:0] pulse_period_ms;

  reg_idx_t reg_sel;
  logic     reg_write;

  assign pready    = 1'b1;
  assign reg_sel   = reg_idx_t'(paddr[ApbAddrWidth-1:2]);
  assign reg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_battery_percent <= LowBatteryReset;
      reconnect_ms        <= ConnectingReset;
      advertising_ms      <= AdvertisingReset;
      step_ms             <= StepReset;
      flash_count         <= FlashCountReset;
      user_window_ms      <= UserWindowReset;
      pulse_ms            <= PulseReset;
      pulse_period_ms     <= PulsePeriodReset;
    end else if (reg_write) begin
      unique case (reg_sel)
        REG_LOW_BATTERY:  low_battery_percent <= pwdata[6:0];
        REG_CONNECTING:   reconnect_ms        <= pwdata[15:0];
        REG_ADVERTISING:  advertising_ms      <= pwdata[15:0];
        REG_STEP:         step_ms             <= pwdata[15:0];
        REG_FLASH_COUNT:  flash_count         <= pwdata[3:0];
        REG_USER_WINDOW:  user_window_ms      <= pwdata[15:0];
        REG_PULSE:        pulse_ms            <= pwdata[15:0];
        REG_PULSE_PERIOD: pulse_period_ms     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_LOW_BATTERY:  prdata[6:0]  = low_battery_percent;
      REG_CONNECTING:   prdata[15:0] = reconnect_ms;
      REG_ADVERTISING:  prdata[15:0] = advertising_ms;
      REG_STEP:         prdata[15:0] = step_ms;
      REG_FLASH_COUNT:  prdata[3:0]  = flash_count;
      REG_USER_WINDOW:  prdata[15:0] = user_window_ms;
      REG_PULSE:        prdata[15:0] = pulse_ms;
      REG_PULSE_PERIOD: prdata[15:0] = pulse_period_ms;
      default:          prdata       = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic       in_valid;   // input register holds a tick
  tick_item_t in_item;
  logic       out_valid;  // result register holds an item
  led_item_t  out_item;
  logic       out_free;   // result register can take a new item this cycle
  logic       step_fire;  // tick moves from input register into the mode logic

  assign out_free   = !out_valid || status.ready;
  assign step_fire  = in_valid && out_free;
  assign tick.ready = !in_valid || out_free;

  assign status.valid = out_valid;
  assign status.item  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.ready && tick.valid) begin
      in_item <= tick.item;
    end
  end

  // ---------------- sequencer state ----------------
  mode_t       current_mode;
  logic [15:0] step_age;
  logic [7:0]  phase_count;
  logic [15:0] pulse_position;
  logic [15:0] episode_age;
  logic [15:0] user_action_age;
  logic        last_connected;
  logic        last_open;
  logic        last_usb;
  logic [2:0]  last_profile;

  mode_t       current_mode_next;
  logic [15:0] step_age_next;
  logic [7:0]  phase_count_next;
  logic [15:0] pulse_position_next;
  logic [15:0] episode_age_next;
  logic [15:0] user_action_age_next;
  led_item_t   out_item_next;

  // Working values of the tick being evaluated.
  logic        flash_trigger;
  logic        success_done;
  logic        new_episode;
  logic        mode_change;
  logic        in_window;
  logic [15:0] user_age_now;
  logic [15:0] episode_now;
  logic [15:0] step_now;
  logic [7:0]  phase_now;
  logic [15:0] pulse_now;
  logic [16:0] step_inc;
  logic [16:0] pulse_inc;
  logic [16:0] pulse_end;
  mode_t       target;
  logic        blue;
  logic        red;

  always_comb begin
    user_age_now = (in_item.user_action || in_item.episode_restart) ? '0 : user_action_age;

    flash_trigger = in_item.success_request || (in_item.link_connected && !last_connected);
    new_episode  = !in_item.link_connected &&
                   (last_connected || (in_item.slot_open != last_open) ||
                    (in_item.profile_number != last_profile) ||
                    (last_usb && !in_item.usb_on));
    success_done = phase_count >= {3'b000, flash_count, 1'b0};

    // Episode clock restarts on an explicit restart, a new disconnected
    // episode, or a success flash that finishes while disconnected.
    if (in_item.episode_restart || new_episode ||
        ((current_mode == MODE_SUCCESS) && !flash_trigger &&
         !in_item.link_connected && success_done)) begin
      episode_now = '0;
    end else begin
      episode_now = episode_age;
    end

    in_window = !in_item.usb_on || (user_age_now < user_window_ms);

    priority if (in_item.sleeping) begin
      target = MODE_SLEEP;
    end else if (in_item.menu_active) begin
      target = MODE_MENU;
    end else if (flash_trigger || ((current_mode == MODE_SUCCESS) && !success_done)) begin
      target = MODE_SUCCESS;
    end else if (!in_item.link_connected && in_window && in_item.slot_open &&
                 (episode_now < advertising_ms)) begin
      target = MODE_ADVERTISING;
    end else if (!in_item.link_connected && in_window && !in_item.slot_open &&
                 (episode_now < reconnect_ms)) begin
      target = MODE_CONNECTING;
    end else if (in_item.usb_on) begin
      target = MODE_LOCK;
    end else begin
      target = MODE_REST;
    end

    // Mode entry (or a success restart) clears the mode timers.
    mode_change = (target != current_mode) || (flash_trigger && (current_mode == MODE_SUCCESS));
    step_now    = mode_change ? '0 : step_age;
    phase_now   = mode_change ? '0 : phase_count;
    pulse_now   = mode_change ? '0 : pulse_position;
    pulse_end   = {1'b0, pulse_now} + {1'b0, pulse_ms};

    blue = 1'b0;
    red  = 1'b0;
    unique case (target)
      MODE_SLEEP: begin
        blue = 1'b0;
        red  = 1'b0;
      end
      MODE_LOCK: begin
        blue = in_item.num_lock;
        red  = in_item.caps_lock;
      end
      MODE_MENU: begin
        blue = 1'b1;
        red  = 1'b1;
      end
      MODE_SUCCESS: begin
        blue = phase_now[0];
        red  = phase_now[0];
      end
      MODE_CONNECTING: begin
        if (phase_now != '0) begin
          blue = phase_now[0];
          red  = !phase_now[0];
        end
      end
      MODE_ADVERTISING: begin
        blue = phase_now[0];
      end
      MODE_REST: begin
        if (in_item.battery_percent <= low_battery_percent) begin
          red = pulse_end >= {1'b0, pulse_period_ms};
        end
      end
      default: ;
    endcase

    out_item_next.blue_on    = blue;
    out_item_next.red_led    = red;
    out_item_next.shown_mode = target;

    // End of tick: timers advance one millisecond; phase advances once per step.
    current_mode_next    = target;
    episode_age_next     = (episode_now == AgeMax) ? AgeMax : episode_now + 16'd1;
    user_action_age_next = (user_age_now == AgeMax) ? AgeMax : user_age_now + 16'd1;

    step_inc = {1'b0, step_now} + 17'd1;
    if (step_inc >= {1'b0, step_ms}) begin
      step_age_next    = '0;
      phase_count_next = (phase_now == PhaseMax) ? PhaseWrap : phase_now + 8'd1;
    end else begin
      step_age_next    = step_inc[15:0];
      phase_count_next = phase_now;
    end

    pulse_inc = {1'b0, pulse_now} + 17'd1;
    if (pulse_inc >= {1'b0, pulse_period_ms}) begin
      pulse_position_next = '0;
    end else begin
      pulse_position_next = pulse_inc[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_mode    <= MODE_REST;
      step_age        <= '0;
      phase_count     <= '0;
      pulse_position  <= '0;
      episode_age     <= '0;
      user_action_age <= AgeMax;
      last_connected  <= 1'b0;
      last_open       <= 1'b0;
      last_usb        <= 1'b0;
      last_profile    <= '0;
    end else if (step_fire) begin
      current_mode    <= current_mode_next;
      step_age        <= step_age_next;
      phase_count     <= phase_count_next;
      pulse_position  <= pulse_position_next;
      episode_age     <= episode_age_next;
      user_action_age <= user_action_age_next;
      last_connected  <= in_item.link_connected;
      last_open       <= in_item.slot_open;
      last_usb        <= in_item.usb_on;
      last_profile    <= in_item.profile_number;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_item <= out_item_next;
    end
  end

endmodule

`default_nettype wire

### design/slms_checker.sv
// Port-level checks for the status LED mode sequencer, bound to the top level.
`default_nettype none

module slms_checker import slms_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire led_item_t out_item
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // Menu lights both LEDs; sleep lights none.
  a_menu_leds: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.shown_mode == MODE_MENU) |->
      out_item.blue_on && out_item.red_led)
    else $error("menu mode without both LEDs");

  a_sleep_dark: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.shown_mode == MODE_SLEEP) |->
      !out_item.blue_on && !out_item.red_led)
    else $error("LED lit in sleep mode");

  // Advertising blinks blue only.
  a_adv_blue_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.shown_mode == MODE_ADVERTISING) |-> !out_item.red_led)
    else $error("red lit while advertising");

endmodule

bind status_led_mode_sequencer_top slms_checker u_slms_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (status.valid),
  .out_ready (status.ready),
  .out_item  (status.item)
);

`default_nettype wire
